// File: rtl/fan_command_state_machine_macros.svh
// ----------------------------------------------------------------------------
// fan command state machine assertion macros
// Wraps concurrent assertions so that they drop out of synthesis.
// ----------------------------------------------------------------------------
`ifndef FAN_COMMAND_STATE_MACHINE_MACROS_SVH
`define FAN_COMMAND_STATE_MACHINE_MACROS_SVH

`ifndef SYNTHESIS

// same cycle implication
`define FCSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same cycle check");

// next cycle implication
`define FCSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle check");

`else

`define FCSM_ASSERT_SAME(label, clk, rst, ante, cons)
`define FCSM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/fcsm_pkg.sv
// ----------------------------------------------------------------------------
// fcsm_pkg
// Types and constants of the fan command state machine.
// ----------------------------------------------------------------------------
package fcsm_pkg;

   localparam logic [3:0] OP_ON         = 4'd0;
   localparam logic [3:0] OP_OFF        = 4'd1;
   localparam logic [3:0] OP_TOGGLE     = 4'd2;
   localparam logic [3:0] OP_SET_SPEED  = 4'd3;
   localparam logic [3:0] OP_CYCLE      = 4'd4;
   localparam logic [3:0] OP_SET_DIR    = 4'd5;
   localparam logic [3:0] OP_DIR_TOGGLE = 4'd6;
   localparam logic [3:0] OP_COMBINED   = 4'd7;
   localparam logic [3:0] OP_ESTOP      = 4'd8;
   localparam logic [3:0] OP_MODE       = 4'd9;
   localparam logic [3:0] OP_BUTTON     = 4'd10;

   localparam logic [1:0] DREQ_EXHAUST = 2'd1;
   localparam logic [1:0] DREQ_INTAKE  = 2'd2;

   localparam logic DIR_EXHAUST = 1'b0;
   localparam logic DIR_INTAKE  = 1'b1;
   localparam logic MODE_MANUAL = 1'b0;

   localparam logic [6:0] SPEED_20  = 7'd20;
   localparam logic [6:0] SPEED_40  = 7'd40;
   localparam logic [6:0] SPEED_60  = 7'd60;
   localparam logic [6:0] SPEED_80  = 7'd80;
   localparam logic [6:0] SPEED_100 = 7'd100;

   typedef struct packed {
      logic [3:0] operation;
      logic [7:0] speed_request;
      logic [1:0] direction_request;
      logic       mode_request;
      logic       button_is_speed;
      logic       button_is_hold;
   } req_type;

   typedef struct packed {
      logic signed [7:0] drive_level;
      logic              brake_pulse;
      logic              is_running;
      logic [6:0]        speed_now;
      logic              direction_now;
      logic              mode_now;
   } rsp_type;

   typedef struct packed {
      logic       run;
      logic [6:0] speed;
      logic       dir;
      logic       mode;
   } state_type;

endpackage

// File: rtl/fan_command_state_machine.sv
// Path: an accepted item is held in the input register; the state update and drive
// mux are combinational; the result is registered when not stalled, shown on rsp_.
// Throughput: one item per cycle unless rsp_stall holds the output.
// Reset: clears both valid flags and sets the fan stopped, speed 20, exhaust,
// manual mode.
// ----------------------------------------------------------------------------
// fan_command_state_machine
// Fan motor command controller with input and result registers.
// ----------------------------------------------------------------------------
`include "fan_command_state_machine_macros.svh"

module fan_command_state_machine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fcsm_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fcsm_pkg::rsp_type rsp_item
);

   logic                in_valid_ff;
   logic                in_valid_in;
   fcsm_pkg::req_type   in_item_ff;
   fcsm_pkg::req_type   in_item_in;
   fcsm_pkg::state_type state_ff;
   fcsm_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   fcsm_pkg::rsp_type   rsp_item_ff;
   fcsm_pkg::rsp_type   rsp_item_in;

   fcsm_pkg::state_type nxt_state;
   logic                nxt_brake;
   logic                advance;
   logic                fire;
   logic                take;
   logic [7:0]          mag;

   fcsm_next u_next (
      .req   (in_item_ff),
      .cur   (state_ff),
      .nxt   (nxt_state),
      .brake (nxt_brake)
   );

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = in_valid_ff && advance;
   assign take    = req_valid && !req_stall;

   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign mag = {1'b0, nxt_state.speed};

   always_comb begin
      in_valid_in  = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      in_item_in   = take ? req_item : in_item_ff;
      state_in     = fire ? nxt_state : state_ff;
      rsp_valid_in = fire ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);
      rsp_item_in  = rsp_item_ff;
      if (fire) begin
         if (!nxt_state.run) begin
            rsp_item_in.drive_level = 8'sd0;
         end else if (nxt_state.dir == fcsm_pkg::DIR_INTAKE) begin
            rsp_item_in.drive_level = $signed(8'(-mag));
         end else begin
            rsp_item_in.drive_level = $signed(mag);
         end
         rsp_item_in.brake_pulse   = nxt_brake;
         rsp_item_in.is_running    = nxt_state.run;
         rsp_item_in.speed_now     = nxt_state.speed;
         rsp_item_in.direction_now = nxt_state.dir;
         rsp_item_in.mode_now      = nxt_state.mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff.run   <= 1'b0;
         state_ff.speed <= fcsm_pkg::SPEED_20;
         state_ff.dir   <= fcsm_pkg::DIR_EXHAUST;
         state_ff.mode  <= fcsm_pkg::MODE_MANUAL;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   `FCSM_ASSERT_SAME(a_brake_stops, clock, reset, rsp_valid && rsp_item.brake_pulse, !rsp_item.is_running && rsp_item.drive_level == 8'sd0)
   `FCSM_ASSERT_SAME(a_stopped_no_drive, clock, reset, rsp_valid && !rsp_item.is_running, rsp_item.drive_level == 8'sd0)
   `FCSM_ASSERT_NEXT(a_state_holds, clock, reset, !fire, $stable(state_ff))
   `FCSM_ASSERT_SAME(a_speed_range, clock, reset, 1'b1, state_ff.speed != 7'd0 && state_ff.speed <= fcsm_pkg::SPEED_100)

endmodule

// File: rtl/fcsm_next.sv
// ----------------------------------------------------------------------------
// fcsm_next
// Next state decode: maps button events and commands onto the fan state.
// ----------------------------------------------------------------------------
module fcsm_next (
   input  fcsm_pkg::req_type   req,
   input  fcsm_pkg::state_type cur,
   output fcsm_pkg::state_type nxt,
   output logic                brake
);

   function automatic logic [6:0] cycle_speed(input logic [6:0] spd);
      logic [6:0] res;
      if (spd < fcsm_pkg::SPEED_40) begin
         res = fcsm_pkg::SPEED_40;
      end else if (spd < fcsm_pkg::SPEED_60) begin
         res = fcsm_pkg::SPEED_60;
      end else if (spd < fcsm_pkg::SPEED_80) begin
         res = fcsm_pkg::SPEED_80;
      end else if (spd < fcsm_pkg::SPEED_100) begin
         res = fcsm_pkg::SPEED_100;
      end else begin
         res = fcsm_pkg::SPEED_20;
      end
      return res;
   endfunction

   function automatic logic apply_dir(input logic dir, input logic [1:0] dreq);
      logic res;
      res = dir;
      if (dreq == fcsm_pkg::DREQ_EXHAUST) begin
         res = fcsm_pkg::DIR_EXHAUST;
      end else if (dreq == fcsm_pkg::DREQ_INTAKE) begin
         res = fcsm_pkg::DIR_INTAKE;
      end
      return res;
   endfunction

   logic       spd_valid;
   logic       spd_over;
   logic [6:0] spd_clamped;

   assign spd_valid   = (req.speed_request != 8'd0) &&
                        (req.speed_request <= {1'b0, fcsm_pkg::SPEED_100});
   assign spd_over    = req.speed_request > {1'b0, fcsm_pkg::SPEED_100};
   assign spd_clamped = spd_over ? fcsm_pkg::SPEED_100 : req.speed_request[6:0];

   always_comb begin
      nxt   = cur;
      brake = 1'b0;
      unique case (req.operation)
         fcsm_pkg::OP_ON: begin
            nxt.run = 1'b1;
            if (req.speed_request != 8'd0) begin
               nxt.speed = spd_clamped;
            end
            nxt.dir = apply_dir(cur.dir, req.direction_request);
         end
         fcsm_pkg::OP_OFF: begin
            nxt.run = 1'b0;
         end
         fcsm_pkg::OP_TOGGLE: begin
            nxt.run = ~cur.run;
         end
         fcsm_pkg::OP_SET_SPEED: begin
            if (spd_valid) begin
               nxt.speed = req.speed_request[6:0];
               nxt.run   = 1'b1;
            end
         end
         fcsm_pkg::OP_CYCLE: begin
            nxt.speed = cycle_speed(cur.speed);
         end
         fcsm_pkg::OP_SET_DIR: begin
            nxt.dir = apply_dir(cur.dir, req.direction_request);
         end
         fcsm_pkg::OP_DIR_TOGGLE: begin
            nxt.dir = ~cur.dir;
         end
         fcsm_pkg::OP_COMBINED: begin
            if (spd_valid) begin
               nxt.speed = req.speed_request[6:0];
            end
            nxt.dir = apply_dir(cur.dir, req.direction_request);
            nxt.run = 1'b1;
         end
         fcsm_pkg::OP_ESTOP: begin
            nxt.run = 1'b0;
            brake   = 1'b1;
         end
         fcsm_pkg::OP_MODE: begin
            nxt.mode = req.mode_request;
         end
         fcsm_pkg::OP_BUTTON: begin
            if (!cur.run) begin
               nxt.run = 1'b1;
               if (req.button_is_hold) begin
                  nxt.speed = fcsm_pkg::SPEED_20;
                  nxt.dir   = req.button_is_speed ? fcsm_pkg::DIR_INTAKE
                                                  : fcsm_pkg::DIR_EXHAUST;
               end
            end else if (req.button_is_hold) begin
               nxt.run = 1'b0;
            end else if (req.button_is_speed) begin
               nxt.speed = cycle_speed(cur.speed);
            end else begin
               nxt.dir = ~cur.dir;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// File: verif/fan_command_state_machine_tb.sv
// ----------------------------------------------------------------------------
// fan_command_state_machine_tb
// Self-checking bench for the fan command controller. A directed list of
// commands and button events is followed by random items. Each accepted item
// is run through a local model of the run flag, speed, direction and mode, and
// every result is compared with the oldest predicted status. The sender works
// in bursts with random gaps, the receiver stalls on its own pattern and holds
// off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module fan_command_state_machine_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] OP_UNKNOWN_FIRST = 4'd11;
   localparam logic [3:0] OP_UNKNOWN_LAST  = 4'd15;
   localparam logic [1:0] DREQ_NONE        = 2'd0;
   localparam logic [1:0] DREQ_INVALID     = 2'd3;
   localparam logic [7:0] SPEED_KEEP       = 8'd0;
   localparam logic [7:0] SPEED_MAX_REQ    = 8'd100;
   localparam int         RANDOM_ITEMS     = 1600;
   localparam int         CYCLE_LIMIT      = 200000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_CHOPPY} stall_style_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   fcsm_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   fcsm_pkg::rsp_type rsp_item;

   fcsm_pkg::req_type pending_cmds[$];
   fcsm_pkg::rsp_type expected_status[$];

   logic       fan_on = 1'b0;
   logic [6:0] fan_speed = fcsm_pkg::SPEED_20;
   logic       fan_dir = fcsm_pkg::DIR_EXHAUST;
   logic       fan_mode = fcsm_pkg::MODE_MANUAL;

   int error_count = 0;
   int cycle_count = 0;
   int accepted_items = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int next_hold_at = 300;
   int style_left = 0;
   logic offer;
   logic stall_next;
   stall_style_type stall_style = STALL_NONE;
   fcsm_pkg::rsp_type want;

   fan_command_state_machine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic fcsm_pkg::req_type make_cmd(logic [3:0] op, logic [7:0] spd,
                                                  logic [1:0] dreq, logic mreq,
                                                  logic is_speed, logic is_hold);
      fcsm_pkg::req_type cmd;
      cmd.operation         = op;
      cmd.speed_request     = spd;
      cmd.direction_request = dreq;
      cmd.mode_request      = mreq;
      cmd.button_is_speed   = is_speed;
      cmd.button_is_hold    = is_hold;
      return cmd;
   endfunction

   function automatic logic [6:0] next_cycle_speed(logic [6:0] spd);
      if (spd < fcsm_pkg::SPEED_40) return fcsm_pkg::SPEED_40;
      else if (spd < fcsm_pkg::SPEED_60) return fcsm_pkg::SPEED_60;
      else if (spd < fcsm_pkg::SPEED_80) return fcsm_pkg::SPEED_80;
      else if (spd < fcsm_pkg::SPEED_100) return fcsm_pkg::SPEED_100;
      return fcsm_pkg::SPEED_20;
   endfunction

   task automatic take_direction(input logic [1:0] dreq);
      if (dreq == fcsm_pkg::DREQ_EXHAUST) fan_dir = fcsm_pkg::DIR_EXHAUST;
      else if (dreq == fcsm_pkg::DREQ_INTAKE) fan_dir = fcsm_pkg::DIR_INTAKE;
   endtask

   task automatic switch_on(input logic [7:0] spd, input logic [1:0] dreq);
      fan_on = 1'b1;
      if (spd != SPEED_KEEP)
         fan_speed = (spd > SPEED_MAX_REQ) ? fcsm_pkg::SPEED_100 : spd[6:0];
      take_direction(dreq);
   endtask

   task automatic apply_fan_command(input fcsm_pkg::req_type cmd);
      fcsm_pkg::rsp_type status;
      logic              brake;
      brake = 1'b0;
      case (cmd.operation)
         fcsm_pkg::OP_ON: begin
            switch_on(cmd.speed_request, cmd.direction_request);
         end
         fcsm_pkg::OP_OFF: begin
            fan_on = 1'b0;
         end
         fcsm_pkg::OP_TOGGLE: begin
            fan_on = ~fan_on;
         end
         fcsm_pkg::OP_SET_SPEED: begin
            if (cmd.speed_request != SPEED_KEEP && cmd.speed_request <= SPEED_MAX_REQ) begin
               fan_speed = cmd.speed_request[6:0];
               fan_on = 1'b1;
            end
         end
         fcsm_pkg::OP_CYCLE: begin
            fan_speed = next_cycle_speed(fan_speed);
         end
         fcsm_pkg::OP_SET_DIR: begin
            take_direction(cmd.direction_request);
         end
         fcsm_pkg::OP_DIR_TOGGLE: begin
            fan_dir = ~fan_dir;
         end
         fcsm_pkg::OP_COMBINED: begin
            if (cmd.speed_request != SPEED_KEEP && cmd.speed_request <= SPEED_MAX_REQ)
               fan_speed = cmd.speed_request[6:0];
            take_direction(cmd.direction_request);
            fan_on = 1'b1;
         end
         fcsm_pkg::OP_ESTOP: begin
            fan_on = 1'b0;
            brake = 1'b1;
         end
         fcsm_pkg::OP_MODE: begin
            fan_mode = cmd.mode_request;
         end
         fcsm_pkg::OP_BUTTON: begin
            if (!fan_on) begin
               if (!cmd.button_is_hold) switch_on(SPEED_KEEP, DREQ_NONE);
               else switch_on({1'b0, fcsm_pkg::SPEED_20},
                              cmd.button_is_speed ? fcsm_pkg::DREQ_INTAKE
                                                  : fcsm_pkg::DREQ_EXHAUST);
            end else if (cmd.button_is_hold) begin
               fan_on = 1'b0;
            end else if (cmd.button_is_speed) begin
               fan_speed = next_cycle_speed(fan_speed);
            end else begin
               fan_dir = ~fan_dir;
            end
         end
         default: begin
         end
      endcase
      if (!fan_on) status.drive_level = 8'sd0;
      else if (fan_dir == fcsm_pkg::DIR_INTAKE)
         status.drive_level = -$signed({1'b0, fan_speed});
      else status.drive_level = $signed({1'b0, fan_speed});
      status.brake_pulse   = brake;
      status.is_running    = fan_on;
      status.speed_now     = fan_speed;
      status.direction_now = fan_dir;
      status.mode_now      = fan_mode;
      expected_status.push_back(status);
   endtask

   function automatic logic [7:0] random_speed_request();
      case ($urandom_range(0, 7))
         0: return SPEED_KEEP;
         1: return 8'd1;
         2: return SPEED_MAX_REQ;
         3: return 8'd101;
         4: return 8'd255;
         5, 6: return 8'($urandom_range(1, 100));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // sender: bursts of items with random gaps, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_fan_command(req_item);
            accepted_items++;
         end
         if (!req_valid || !req_stall) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_cmds.size() > 0) begin
               req_item <= pending_cmds.pop_front();
               offer = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  if ($urandom_range(0, 2) == 0) gap_left = 0;
                  else if ($urandom_range(0, 19) == 0) gap_left = $urandom_range(30, 60);
                  else gap_left = $urandom_range(1, 12);
               end
            end
            req_valid <= offer;
         end
      end
   end

   // receiver: stall pattern changes now and then, with long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_left == 0 && accepted_items >= next_hold_at) begin
            hold_left = $urandom_range(150, 250);
            next_hold_at = next_hold_at + 700;
         end
         if (style_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 200);
         end else begin
            style_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            case (stall_style)
               STALL_LIGHT:  stall_next = ($urandom_range(0, 7) == 0);
               STALL_HEAVY:  stall_next = ($urandom_range(0, 1) == 0);
               STALL_CHOPPY: stall_next = ($urandom_range(0, 3) != 0);
               default:      stall_next = 1'b0;
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // result check against the oldest predicted status
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            if (error_count < 10)
               $display("unexpected result: drive %0d run %0b speed %0d dir %0b",
                        rsp_item.drive_level, rsp_item.is_running, rsp_item.speed_now,
                        rsp_item.direction_now);
            error_count++;
         end else begin
            want = expected_status.pop_front();
            if (rsp_item.drive_level !== want.drive_level ||
                rsp_item.brake_pulse !== want.brake_pulse ||
                rsp_item.is_running !== want.is_running ||
                rsp_item.speed_now !== want.speed_now ||
                rsp_item.direction_now !== want.direction_now ||
                rsp_item.mode_now !== want.mode_now) begin
               if (error_count < 10)
                  $display({"mismatch: exp drive %0d brake %0b run %0b speed %0d dir %0b ",
                            "mode %0b / got drive %0d brake %0b run %0b speed %0d dir %0b ",
                            "mode %0b"},
                           want.drive_level, want.brake_pulse, want.is_running,
                           want.speed_now, want.direction_now, want.mode_now,
                           rsp_item.drive_level, rsp_item.brake_pulse, rsp_item.is_running,
                           rsp_item.speed_now, rsp_item.direction_now, rsp_item.mode_now);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("fan_command_state_machine verification failed");
         $finish;
      end
   end

   initial begin
      fcsm_pkg::req_type cmd;
      int                pick;
      // directed part
      pending_cmds.push_back(make_cmd(OP_UNKNOWN_LAST, 8'd255, DREQ_INVALID,
                                      1'b1, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_BUTTON, 8'd77, fcsm_pkg::DREQ_INTAKE,
                                      1'b1, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_BUTTON, SPEED_KEEP, DREQ_NONE,
                                      1'b0, 1'b0, 1'b1));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_BUTTON, SPEED_KEEP, DREQ_NONE,
                                      1'b0, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_BUTTON, SPEED_KEEP, DREQ_NONE,
                                      1'b0, 1'b1, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_BUTTON, SPEED_KEEP, DREQ_NONE,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_BUTTON, SPEED_KEEP, DREQ_NONE,
                                      1'b0, 1'b0, 1'b1));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_BUTTON, SPEED_KEEP, fcsm_pkg::DREQ_INTAKE,
                                      1'b0, 1'b0, 1'b1));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_SET_SPEED, SPEED_KEEP, DREQ_NONE,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_SET_SPEED, 8'd101, DREQ_NONE,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_SET_SPEED, SPEED_MAX_REQ, DREQ_NONE,
                                      1'b0, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_CYCLE, SPEED_KEEP, DREQ_NONE,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_SET_SPEED, 8'd55, DREQ_NONE,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_CYCLE, 8'd255, DREQ_INVALID,
                                      1'b1, 1'b1, 1'b1));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_ON, 8'd255, fcsm_pkg::DREQ_INTAKE,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_TOGGLE, SPEED_KEEP, DREQ_NONE,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_ON, SPEED_KEEP, DREQ_INVALID,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_SET_DIR, SPEED_KEEP, DREQ_INVALID,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_SET_DIR, SPEED_KEEP, fcsm_pkg::DREQ_EXHAUST,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_DIR_TOGGLE, SPEED_KEEP, DREQ_NONE,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_ESTOP, SPEED_KEEP, DREQ_NONE,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_COMBINED, 8'd200, DREQ_INVALID,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_COMBINED, 8'd1, fcsm_pkg::DREQ_INTAKE,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_MODE, SPEED_KEEP, DREQ_NONE,
                                      1'b1, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_OFF, SPEED_KEEP, DREQ_NONE,
                                      1'b0, 1'b0, 1'b0));
      pending_cmds.push_back(make_cmd(fcsm_pkg::OP_MODE, 8'd255, DREQ_INVALID,
                                      1'b0, 1'b1, 1'b1));
      // random part
      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 15);
         if (pick == 0)
            cmd.operation = 4'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
         else if (pick < 4)
            cmd.operation = fcsm_pkg::OP_BUTTON;
         else
            cmd.operation = 4'($urandom_range(fcsm_pkg::OP_ON, fcsm_pkg::OP_MODE));
         cmd.speed_request     = random_speed_request();
         cmd.direction_request = 2'($urandom_range(0, 3));
         cmd.mode_request      = 1'($urandom_range(0, 1));
         cmd.button_is_speed   = 1'($urandom_range(0, 1));
         cmd.button_is_hold    = ($urandom_range(0, 3) == 0);
         pending_cmds.push_back(cmd);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_valid) @(posedge clock);
      while (expected_status.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("fan_command_state_machine verification clean");
      end else begin
         $display("fan_command_state_machine verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/fcsm_pkg.sv
rtl/fcsm_next.sv
rtl/fan_command_state_machine.sv
verif/fan_command_state_machine_tb.sv
